// File: rtl/obb_pkg.sv
// Shared widths and the reset constant for the oriented-box overlap core.
`timescale 1ns / 1ps
`default_nettype none
package obb_pkg;
    localparam int unsigned COMP_W   = 16;       // one packed Q12.4 / Q1.14 component
    localparam int unsigned FIELD_W  = 48;       // three components, x low
    localparam int unsigned THR_W    = 29;       // threshold, Q2.28
    localparam logic [THR_W-1:0] THR_RESET = 29'd268432773;

    localparam int unsigned DOT_W    = 34;       // R entries, signed Q2.28
    localparam int unsigned ABS_W    = 33;       // |R|
    localparam int unsigned OFS_W    = 35;       // projected offsets
    localparam int unsigned PART_W   = 52;       // partial products, radius sums
    localparam int unsigned CMP_W    = 72;       // final exact compare width
    localparam int unsigned UNIT_SH  = 28;       // one in Q2.28
    localparam int unsigned FACE_SH  = 14;       // Q.32 radius vs Q.18 offset
    localparam int unsigned LO_W     = 17;       // low slice of an offset

    typedef logic signed [COMP_W-1:0] t_comp;
    typedef logic signed [DOT_W-1:0]  t_dot;
    typedef logic        [ABS_W-1:0]  t_abs;
    typedef logic signed [OFS_W-1:0]  t_ofs;
    typedef logic signed [PART_W-1:0] t_part;
    typedef logic signed [CMP_W-1:0]  t_cmp;
endpackage
`default_nettype wire

// File: rtl/obb_obb_overlap_test_core.sv
// Streaming oriented-box overlap test over the fifteen separating axes.
//
// Input channel: i_valid / o_stall carry one beat holding two boxes (src and
// dst), each as center, three axes and half lengths, 16-bit components packed
// x low. Output channel: o_valid / i_stall carry one beat with o_overlap.
// Every input beat yields exactly one output beat, in order.
//
// Throughput is one beat per clock while the output is not stalled: the
// pipeline has five register stages (products, dot sums, radius and cross
// partial products, sums, compare) and a new beat may enter each cycle.
//
// A stall on the output freezes every stage together while the last stage
// holds a beat; o_stall then rises so nothing is dropped or repeated.
// Bubbles advance freely when the output is not holding.
//
// i_rst_n (synchronous, active low) clears all valid bits and loads the
// parallel threshold with its reset value of about 0.99999 in Q2.28.
// i_cfg_we writes the threshold; write it only while the pipeline is empty.
`timescale 1ns / 1ps
`default_nettype none
module obb_obb_overlap_test_core (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire [obb_pkg::THR_W-1:0]          i_cfg_wdata,
    input  wire                               i_valid,
    output logic                              o_stall,
    input  wire [obb_pkg::FIELD_W-1:0]        i_src_center,
    input  wire [obb_pkg::FIELD_W-1:0]        i_src_axis_x,
    input  wire [obb_pkg::FIELD_W-1:0]        i_src_axis_y,
    input  wire [obb_pkg::FIELD_W-1:0]        i_src_axis_z,
    input  wire [obb_pkg::FIELD_W-1:0]        i_src_half,
    input  wire [obb_pkg::FIELD_W-1:0]        i_dst_center,
    input  wire [obb_pkg::FIELD_W-1:0]        i_dst_axis_x,
    input  wire [obb_pkg::FIELD_W-1:0]        i_dst_axis_y,
    input  wire [obb_pkg::FIELD_W-1:0]        i_dst_axis_z,
    input  wire [obb_pkg::FIELD_W-1:0]        i_dst_half,
    output logic                              o_valid,
    input  wire                               i_stall,
    output logic                              o_overlap
);
    import obb_pkg::*;

    localparam int unsigned NSTG = 5;

    logic [THR_W-1:0] r_thr;
    logic [NSTG-1:0]  r_vld;
    logic             en;

    // advance all stages unless the output holds a stalled beat
    assign en      = !(r_vld[NSTG-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    // ---------------- stage 1: unpack, offset, elementwise products
    t_comp a [3][3];
    t_comp b [3][3];
    t_comp ha [3];
    t_comp hb [3];
    logic signed [COMP_W:0] t [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            a[0][k] = t_comp'(i_src_axis_x[k*COMP_W +: COMP_W]);
            a[1][k] = t_comp'(i_src_axis_y[k*COMP_W +: COMP_W]);
            a[2][k] = t_comp'(i_src_axis_z[k*COMP_W +: COMP_W]);
            b[0][k] = t_comp'(i_dst_axis_x[k*COMP_W +: COMP_W]);
            b[1][k] = t_comp'(i_dst_axis_y[k*COMP_W +: COMP_W]);
            b[2][k] = t_comp'(i_dst_axis_z[k*COMP_W +: COMP_W]);
            ha[k]   = t_comp'(i_src_half[k*COMP_W +: COMP_W]);
            hb[k]   = t_comp'(i_dst_half[k*COMP_W +: COMP_W]);
            t[k]    = (COMP_W+1)'(t_comp'(i_dst_center[k*COMP_W +: COMP_W]))
                    - (COMP_W+1)'(t_comp'(i_src_center[k*COMP_W +: COMP_W]));
        end
    end

    logic signed [2*COMP_W-1:0] r1_ab [3][3][3];
    logic signed [2*COMP_W:0]   r1_ta [3][3];
    logic signed [2*COMP_W:0]   r1_tb [3][3];
    t_comp                      r1_ha [3];
    t_comp                      r1_hb [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r1_ha[i] <= ha[i];
                r1_hb[i] <= hb[i];
                for (int k = 0; k < 3; k++) begin
                    r1_ta[i][k] <= t[k] * a[i][k];
                    r1_tb[i][k] <= t[k] * b[i][k];
                    for (int j = 0; j < 3; j++) begin
                        r1_ab[i][j][k] <= a[i][k] * b[j][k];
                    end
                end
            end
        end
    end

    // ---------------- stage 2: dot sums, magnitudes, parallel flag
    t_dot  n2_r  [3][3];
    t_abs  n2_ar [3][3];
    t_ofs  n2_ta [3];
    t_ofs  n2_tb [3];
    logic  n2_par;

    always_comb begin
        n2_par = 1'b0;
        for (int i = 0; i < 3; i++) begin
            n2_ta[i] = OFS_W'(r1_ta[i][0]) + OFS_W'(r1_ta[i][1]) + OFS_W'(r1_ta[i][2]);
            n2_tb[i] = OFS_W'(r1_tb[i][0]) + OFS_W'(r1_tb[i][1]) + OFS_W'(r1_tb[i][2]);
            for (int j = 0; j < 3; j++) begin
                n2_r[i][j] = DOT_W'(r1_ab[i][j][0]) + DOT_W'(r1_ab[i][j][1])
                           + DOT_W'(r1_ab[i][j][2]);
                n2_ar[i][j] = n2_r[i][j][DOT_W-1] ? ABS_W'(-n2_r[i][j])
                                                  : ABS_W'(n2_r[i][j]);
                if (n2_ar[i][j] > ABS_W'(r_thr)) begin
                    n2_par = 1'b1;
                end
            end
        end
    end

    t_dot  r2_r  [3][3];
    t_abs  r2_ar [3][3];
    t_ofs  r2_ta [3];
    t_ofs  r2_tb [3];
    t_comp r2_ha [3];
    t_comp r2_hb [3];
    logic  r2_par;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_r   <= n2_r;
            r2_ar  <= n2_ar;
            r2_ta  <= n2_ta;
            r2_tb  <= n2_tb;
            r2_ha  <= r1_ha;
            r2_hb  <= r1_hb;
            r2_par <= n2_par;
        end
    end

    // ---------------- stage 3: radius products and cross partial products
    // r3_haar[x][y][j] = ha[x]*|R[y][j]|, r3_hbar[x][i][y] = hb[x]*|R[i][y]|
    // r3_plo/phi[m][n][j] = low/high slice of ta[m] times R[n][j]
    t_part r3_haar [3][3][3];
    t_part r3_hbar [3][3][3];
    t_part r3_plo  [3][3][3];
    t_part r3_phi  [3][3][3];
    t_ofs  r3_ta [3];
    t_ofs  r3_tb [3];
    t_comp r3_ha [3];
    t_comp r3_hb [3];
    logic  r3_par;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_ta  <= r2_ta;
            r3_tb  <= r2_tb;
            r3_ha  <= r2_ha;
            r3_hb  <= r2_hb;
            r3_par <= r2_par;
            for (int x = 0; x < 3; x++) begin
                for (int y = 0; y < 3; y++) begin
                    for (int j = 0; j < 3; j++) begin
                        r3_haar[x][y][j] <= r2_ha[x] * $signed({1'b0, r2_ar[y][j]});
                        r3_hbar[x][y][j] <= r2_hb[x] * $signed({1'b0, r2_ar[y][j]});
                        r3_plo[x][y][j]  <= $signed({1'b0, r2_ta[x][LO_W-1:0]})
                                          * r2_r[y][j];
                        r3_phi[x][y][j]  <= $signed(r2_ta[x][OFS_W-1:LO_W]) * r2_r[y][j];
                    end
                end
            end
        end
    end

    // ---------------- stage 4: radius sums and cross projections
    t_part n4_rfa [3];
    t_part n4_rfb [3];
    t_part n4_rx  [3][3];
    t_cmp  n4_px  [3][3];
    t_cmp  pp     [3][3][3];

    always_comb begin
        for (int m = 0; m < 3; m++) begin
            for (int n = 0; n < 3; n++) begin
                for (int j = 0; j < 3; j++) begin
                    pp[m][n][j] = (CMP_W'(r3_phi[m][n][j]) <<< LO_W)
                                + CMP_W'(r3_plo[m][n][j]);
                end
            end
        end
        for (int i = 0; i < 3; i++) begin
            n4_rfa[i] = (PART_W'(r3_ha[i]) <<< UNIT_SH) + r3_hbar[0][i][0]
                      + r3_hbar[1][i][1] + r3_hbar[2][i][2];
            n4_rfb[i] = r3_haar[0][0][i] + r3_haar[1][1][i] + r3_haar[2][2][i]
                      + (PART_W'(r3_hb[i]) <<< UNIT_SH);
            for (int j = 0; j < 3; j++) begin
                n4_rx[i][j] = r3_haar[(i+1)%3][(i+2)%3][j] + r3_haar[(i+2)%3][(i+1)%3][j]
                            + r3_hbar[(j+1)%3][i][(j+2)%3] + r3_hbar[(j+2)%3][i][(j+1)%3];
                n4_px[i][j] = pp[(i+2)%3][(i+1)%3][j] - pp[(i+1)%3][(i+2)%3][j];
            end
        end
    end

    t_part r4_rfa [3];
    t_part r4_rfb [3];
    t_part r4_rx  [3][3];
    t_cmp  r4_px  [3][3];
    t_ofs  r4_ta  [3];
    t_ofs  r4_tb  [3];
    logic  r4_par;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_rfa <= n4_rfa;
            r4_rfb <= n4_rfb;
            r4_rx  <= n4_rx;
            r4_px  <= n4_px;
            r4_ta  <= r3_ta;
            r4_tb  <= r3_tb;
            r4_par <= r3_par;
        end
    end

    // ---------------- stage 5: exact compares and verdict
    // face axes: |ta * 2^28| > rad * 2^14 reduces to |ta| * 2^14 > rad
    logic n5_face_sep;
    logic n5_cross_sep;
    t_cmp mag;

    always_comb begin
        n5_face_sep  = 1'b0;
        n5_cross_sep = 1'b0;
        mag          = '0;
        for (int i = 0; i < 3; i++) begin
            mag = r4_ta[i][OFS_W-1] ? -CMP_W'(r4_ta[i]) : CMP_W'(r4_ta[i]);
            if ((mag <<< FACE_SH) > CMP_W'(r4_rfa[i])) begin
                n5_face_sep = 1'b1;
            end
            mag = r4_tb[i][OFS_W-1] ? -CMP_W'(r4_tb[i]) : CMP_W'(r4_tb[i]);
            if ((mag <<< FACE_SH) > CMP_W'(r4_rfb[i])) begin
                n5_face_sep = 1'b1;
            end
            for (int j = 0; j < 3; j++) begin
                mag = r4_px[i][j][CMP_W-1] ? -r4_px[i][j] : r4_px[i][j];
                if (mag > (CMP_W'(r4_rx[i][j]) <<< FACE_SH)) begin
                    n5_cross_sep = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_overlap <= !(n5_face_sep || (!r4_par && n5_cross_sep));
        end
    end
endmodule
`default_nettype wire

// File: dv/obb_overlap_checker.sv
// Checker: predicts the overlap flag of every accepted box pair and compares results.
`timescale 1ns / 1ps
module obb_overlap_checker (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_we,
    input  wire [obb_pkg::THR_W-1:0]   i_cfg_wdata,
    input  wire                        i_valid,
    input  wire                        i_stall_in,
    input  wire [obb_pkg::FIELD_W-1:0] i_fields [10],
    input  wire                        i_out_valid,
    input  wire                        i_out_stall,
    input  wire                        i_overlap,
    output int                         o_errors,
    output int                         o_pending
);
    import obb_pkg::*;

    typedef logic signed [127:0] t_wide;

    logic [THR_W-1:0] parallel_thr;
    logic             overlap_q [$];

    function automatic longint comp(input logic [FIELD_W-1:0] v, input int k);
        return longint'($signed(v[16*k +: 16]));
    endfunction

    function automatic logic splits(input t_wide proj, input longint rad);
        t_wide mag;
        t_wide lim;
        mag = proj < 0 ? -proj : proj;
        lim = t_wide'(rad) * 16384;
        return mag > lim;
    endfunction

    function automatic logic boxes_overlap(input logic [FIELD_W-1:0] f [10],
                                           input logic [THR_W-1:0] thr);
        longint a [3][3];
        longint b [3][3];
        longint ha [3];
        longint hb [3];
        longint t [3];
        longint ta [3];
        longint tb [3];
        longint r [3][3];
        longint ar [3][3];
        longint rad;
        logic   parallel;
        logic   sep;
        t_wide  proj;
        int     i1, i2, j1, j2;
        parallel = 0;
        sep = 0;
        for (int k = 0; k < 3; k++) begin
            t[k]  = comp(f[5], k) - comp(f[0], k);
            ha[k] = comp(f[4], k);
            hb[k] = comp(f[9], k);
            for (int i = 0; i < 3; i++) begin
                a[i][k] = comp(f[1+i], k);
                b[i][k] = comp(f[6+i], k);
            end
        end
        for (int i = 0; i < 3; i++) begin
            ta[i] = 0;
            tb[i] = 0;
            for (int k = 0; k < 3; k++) begin
                ta[i] += t[k] * a[i][k];
                tb[i] += t[k] * b[i][k];
            end
            for (int j = 0; j < 3; j++) begin
                r[i][j] = a[i][0]*b[j][0] + a[i][1]*b[j][1] + a[i][2]*b[j][2];
                ar[i][j] = r[i][j] < 0 ? -r[i][j] : r[i][j];
                if (ar[i][j] > longint'(thr)) parallel = 1;
            end
        end
        // face axes of the first box, then of the second
        for (int i = 0; i < 3; i++) begin
            rad = ha[i]*(64'sd1 << 28) + hb[0]*ar[i][0] + hb[1]*ar[i][1] + hb[2]*ar[i][2];
            if (!sep) sep = splits(t_wide'(ta[i]) * (128'sd1 << 28), rad);
        end
        for (int j = 0; j < 3; j++) begin
            rad = ha[0]*ar[0][j] + ha[1]*ar[1][j] + ha[2]*ar[2][j] + hb[j]*(64'sd1 << 28);
            if (!sep) sep = splits(t_wide'(tb[j]) * (128'sd1 << 28), rad);
        end
        // edge cross axes only when nothing is near parallel
        if (!sep && !parallel) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    i1 = (i + 1) % 3; i2 = (i + 2) % 3;
                    j1 = (j + 1) % 3; j2 = (j + 2) % 3;
                    rad = ha[i1]*ar[i2][j] + ha[i2]*ar[i1][j]
                        + hb[j1]*ar[i][j2] + hb[j2]*ar[i][j1];
                    proj = t_wide'(ta[i2]) * t_wide'(r[i1][j])
                         - t_wide'(ta[i1]) * t_wide'(r[i2][j]);
                    if (!sep) sep = splits(proj, rad);
                end
            end
        end
        return !sep;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
        parallel_thr = THR_RESET;
    end

    always @(posedge i_clk) begin
        logic want;
        if (!i_rst_n) begin
            parallel_thr <= THR_RESET;
        end else begin
            if (i_cfg_we) parallel_thr <= i_cfg_wdata;
            if (i_valid && !i_stall_in) overlap_q.push_back(boxes_overlap(i_fields, parallel_thr));
            if (i_out_valid && !i_out_stall) begin
                if (overlap_q.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    want = overlap_q.pop_front();
                    if (i_overlap !== want)
                        report_mismatch($sformatf("overlap %b, expected %b", i_overlap, want));
                end
            end
            o_pending = overlap_q.size();
        end
    end
endmodule

// File: dv/testbench.sv
// Top of the overlap core testbench: stimulus, output back-pressure and verdict.
`timescale 1ns / 1ps
module testbench;
    import obb_pkg::*;

    localparam int MAX_CYCLES = 400000;
    localparam int DRAIN      = 12;     // pipeline is five deep; leave margin

    logic                i_clk;
    logic                i_rst_n;
    logic                cfg_we;
    logic [THR_W-1:0]    cfg_wdata;
    logic                in_valid;
    logic                in_stall;
    logic [FIELD_W-1:0]  fields [10];
    logic                out_valid;
    logic                out_stall;
    logic                overlap;
    logic                quiet;      // last stretch of the run: no idling anywhere
    int                  errors;
    int                  pending;
    int                  cycles;

    obb_obb_overlap_test_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_src_center(fields[0]), .i_src_axis_x(fields[1]), .i_src_axis_y(fields[2]),
        .i_src_axis_z(fields[3]), .i_src_half(fields[4]),
        .i_dst_center(fields[5]), .i_dst_axis_x(fields[6]), .i_dst_axis_y(fields[7]),
        .i_dst_axis_z(fields[8]), .i_dst_half(fields[9]),
        .o_valid(out_valid), .i_stall(out_stall), .o_overlap(overlap)
    );

    obb_overlap_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_valid(in_valid), .i_stall_in(in_stall), .i_fields(fields),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_overlap(overlap),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    // Hard stop so a hung handshake cannot run forever.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > MAX_CYCLES) begin
            $display("[obb_obb_overlap_test_core] ERROR");
            $finish;
        end
    end

    // Receiver back-pressure: random stall bursts until the quiet stretch.
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet && i_rst_n && $urandom_range(0, 5) == 0) begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
                out_stall = 1'b0;
            end
        end
    end

    function automatic logic [FIELD_W-1:0] pack3(input int x, input int y, input int z);
        logic [15:0] cx, cy, cz;
        cx = x[15:0]; cy = y[15:0]; cz = z[15:0];
        return {cz, cy, cx};
    endfunction

    function automatic logic [FIELD_W-1:0] rand48();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[FIELD_W-1:0];
    endfunction

    // Rotation from three random angles; rows become the box axes in Q1.14.
    task automatic make_frame(output logic [FIELD_W-1:0] ax [3]);
        real a, b, c;
        real m [3][3];
        a = $urandom_range(0, 6283) / 1000.0;
        b = $urandom_range(0, 6283) / 1000.0;
        c = $urandom_range(0, 6283) / 1000.0;
        m[0][0] = $cos(a)*$cos(b);
        m[0][1] = $sin(a)*$cos(b);
        m[0][2] = -$sin(b);
        m[1][0] = $cos(a)*$sin(b)*$sin(c) - $sin(a)*$cos(c);
        m[1][1] = $sin(a)*$sin(b)*$sin(c) + $cos(a)*$cos(c);
        m[1][2] = $cos(b)*$sin(c);
        m[2][0] = $cos(a)*$sin(b)*$cos(c) + $sin(a)*$sin(c);
        m[2][1] = $sin(a)*$sin(b)*$cos(c) - $cos(a)*$sin(c);
        m[2][2] = $cos(b)*$cos(c);
        for (int i = 0; i < 3; i++)
            ax[i] = pack3($rtoi(m[i][0]*16383.0), $rtoi(m[i][1]*16383.0),
                          $rtoi(m[i][2]*16383.0));
    endtask

    // Present one beat and hold it until accepted; valid stays high across beats
    // unless a gap is taken.
    task automatic send_pair(input logic [FIELD_W-1:0] f [10]);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        fields = f;
        in_valid = 1'b1;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    // Wait for an empty pipeline, then write the threshold.
    task automatic write_threshold(input logic [THR_W-1:0] value);
        @(negedge i_clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
        cfg_we = 1'b1;
        cfg_wdata = value;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic send_aligned(input int bx, input int ha, input int hb);
        logic [FIELD_W-1:0] f [10];
        f[0] = pack3(0, 0, 0);
        f[1] = pack3(16384 - 1, 0, 0);
        f[2] = pack3(0, 16383, 0);
        f[3] = pack3(0, 0, 16383);
        f[4] = pack3(ha, ha, ha);
        f[5] = pack3(bx, 0, 0);
        f[6] = f[1]; f[7] = f[2]; f[8] = f[3];
        f[9] = pack3(hb, hb, hb);
        send_pair(f);
    endtask

    // Mostly plausible boxes; some share a frame (parallel shortcut), some are noise.
    task automatic send_random();
        logic [FIELD_W-1:0] f [10];
        logic [FIELD_W-1:0] ax [3];
        int spread, kind;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            foreach (f[k]) f[k] = rand48();
        end else begin
            spread = $urandom_range(0, 3) == 0 ? 4000 : 1200;
            make_frame(ax);
            f[1] = ax[0]; f[2] = ax[1]; f[3] = ax[2];
            if (kind == 1) begin
                f[6] = ax[0]; f[7] = ax[1]; f[8] = ax[2];
            end else begin
                make_frame(ax);
                f[6] = ax[0]; f[7] = ax[1]; f[8] = ax[2];
            end
            f[0] = pack3($urandom_range(0, 2*spread) - spread, $urandom_range(0, 2*spread) - spread,
                         $urandom_range(0, 2*spread) - spread);
            f[5] = pack3($urandom_range(0, 2*spread) - spread, $urandom_range(0, 2*spread) - spread,
                         $urandom_range(0, 2*spread) - spread);
            f[4] = pack3($urandom_range(1, 900), $urandom_range(1, 900), $urandom_range(1, 900));
            f[9] = pack3($urandom_range(1, 900), $urandom_range(1, 900), $urandom_range(1, 900));
            if (kind == 2) f[9] = rand48();   // odd or negative half lengths
        end
        send_pair(f);
    endtask

    initial begin
        logic [FIELD_W-1:0] f [10];
        cycles = 0;
        quiet = 1'b0;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        foreach (fields[k]) fields[k] = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: touching faces overlap, one step further separates.
        send_aligned(32 + 2, 16, 16);
        send_aligned(32, 16, 16);
        send_aligned(-32, 16, 16);
        send_aligned(33, 16, 16);
        send_aligned(0, -16, 8);              // negative half lengths
        // Field extremes.
        foreach (f[k]) f[k] = '0;
        send_pair(f);
        foreach (f[k]) f[k] = '1;
        send_pair(f);
        foreach (f[k]) f[k] = pack3(-32768, -32768, -32768);
        send_pair(f);
        foreach (f[k]) f[k] = pack3(32767, 32767, 32767);
        send_pair(f);
        foreach (f[k]) f[k] = pack3(32767, -32768, 32767);
        f[5] = pack3(-32768, 32767, -32768);
        send_pair(f);
        // Non-unit, non-orthogonal axes.
        for (int n = 0; n < 6; n++) begin
            foreach (f[k]) f[k] = rand48();
            f[4] = pack3($urandom_range(0, 4000), 50, 50);
            send_pair(f);
        end

        // Random phases across thresholds: zero forces the shortcut whenever
        // any dot is nonzero, the max 29-bit value disables it for unit-length axes.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                1: write_threshold('0);
                2: write_threshold({THR_W{1'b1}});
                3: write_threshold(29'd268435456);
                4: write_threshold(29'd134217728);
                default: ;
            endcase
            for (int n = 0; n < 110; n++) send_random();
        end
        write_threshold(THR_RESET);
        quiet = 1'b1;
        for (int n = 0; n < 90; n++) send_random();

        @(negedge i_clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
        if (errors == 0) begin
            $display("[obb_obb_overlap_test_core] OK");
        end else begin
            $display("[obb_obb_overlap_test_core] ERROR");
        end
        $finish;
    end
endmodule
